// File: rtl/vca_pkg.sv
// Shared types and constants of the video color adjust block.
package vca_pkg;

  // Pixel channel width and packed word width
  localparam int PIX_W  = 8;
  localparam int WORD_W = 3 * PIX_W;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SATURATION = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TINT_MODE  = 2'd3;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] BRIGHTNESS_RST = 7'd50;
  localparam logic [CFG_DATA_W-1:0] CONTRAST_RST   = 7'd100;
  localparam logic [CFG_DATA_W-1:0] SATURATION_RST = 7'd50;

  // Tint modes
  localparam logic [2:0] TINT_COLOR = 3'd0;
  localparam logic [2:0] TINT_BW    = 3'd1;
  localparam logic [2:0] TINT_PAPER = 3'd2;
  localparam logic [2:0] TINT_GREEN = 3'd3;
  localparam logic [2:0] TINT_AMBER = 3'd4;
  localparam logic [2:0] TINT_SEPIA = 3'd5;

  // Fixed chroma pairs of the monochrome modes (integer units)
  localparam int PAPER_U = -8;
  localparam int PAPER_V = 5;
  localparam int GREEN_U = -99;
  localparam int GREEN_V = -64;
  localparam int AMBER_U = -104;
  localparam int AMBER_V = 50;
  localparam int SEPIA_U = -31;
  localparam int SEPIA_V = 26;

  // Color matrix coefficients in thousandths (magnitudes)
  localparam int CM_RY = 299;
  localparam int CM_GY = 587;
  localparam int CM_BY = 114;
  localparam int CM_RU = 147;
  localparam int CM_GU = 289;
  localparam int CM_BU = 436;
  localparam int CM_RV = 615;
  localparam int CM_GV = 515;
  localparam int CM_BV = 100;
  localparam int CM_VR = 1140;
  localparam int CM_UG = 396;
  localparam int CM_VG = 581;
  localparam int CM_UB = 2029;

  // Settings that reach the pipeline directly
  typedef struct packed {
    logic signed [7:0] bright_ofs;  // brightness minus 50
    logic [2:0]        tint;
  } vca_adj_t;

endpackage

// File: rtl/vca_cfg_regs.sv
// Configuration registers and derived saturation and contrast scales.
module vca_cfg_regs #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vca_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [vca_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output vca_pkg::vca_adj_t                   adj,
  output logic [FRAC_BITS+1:0]                sat_scale,
  output logic [FRAC_BITS+1:0]                con_scale
);
  import vca_pkg::*;

  localparam int SW    = FRAC_BITS + 2;
  localparam int TAB_N = 1 << CFG_DATA_W;

  // Saturation scale table: round(s * 2^F / 50)
  function automatic logic [TAB_N-1:0][SW-1:0] build_sat_tab();
    logic [TAB_N-1:0][SW-1:0] tab;
    for (int i = 0; i < TAB_N; i++) begin
      tab[i] = SW'(((longint'(i) <<< FRAC_BITS) + 25) / 50);
    end
    return tab;
  endfunction

  // Contrast scale table: round(c * 2^F / 100)
  function automatic logic [TAB_N-1:0][SW-1:0] build_con_tab();
    logic [TAB_N-1:0][SW-1:0] tab;
    for (int i = 0; i < TAB_N; i++) begin
      tab[i] = SW'(((longint'(i) <<< FRAC_BITS) + 50) / 100);
    end
    return tab;
  endfunction

  localparam logic [TAB_N-1:0][SW-1:0] SAT_TAB = build_sat_tab();
  localparam logic [TAB_N-1:0][SW-1:0] CON_TAB = build_con_tab();

  logic signed [7:0] bright_ofs_r;
  logic [2:0]        tint_r;
  logic [SW-1:0]     sat_scale_r;
  logic [SW-1:0]     con_scale_r;
  logic signed [7:0] bright_ofs_nxt;

  // Offset added to luma
  assign bright_ofs_nxt = $signed({1'b0, cfg_wdata}) - $signed({1'b0, BRIGHTNESS_RST});

  // Store settings in their working form
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_ofs_r <= '0;
      tint_r       <= TINT_COLOR;
      sat_scale_r  <= SAT_TAB[SATURATION_RST];
      con_scale_r  <= CON_TAB[CONTRAST_RST];
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BRIGHTNESS: bright_ofs_r <= bright_ofs_nxt;
        REG_CONTRAST:   con_scale_r  <= CON_TAB[cfg_wdata];
        REG_SATURATION: sat_scale_r  <= SAT_TAB[cfg_wdata];
        REG_TINT_MODE:  tint_r       <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  assign adj.bright_ofs = bright_ofs_r;
  assign adj.tint       = tint_r;
  assign sat_scale      = sat_scale_r;
  assign con_scale      = con_scale_r;

endmodule

// File: rtl/video_color_adjust.sv
// Throughput: one pixel per cycle while the output is not stalled; five
// pipeline stages with per-stage valid bits, a stalled stage holds while
// earlier empty stages still fill.
// Reset (rst_n low at a clock edge) empties the pipeline and restores
// brightness 50, contrast 100, saturation 50 and color mode.
// Top level: RGB to YUV, saturation, contrast, brightness, tint, back to RGB.
module video_color_adjust #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vca_pkg::WORD_W-1:0]        in_tdata,   // red_in, green_in, blue_in
  // Output pixel stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [vca_pkg::WORD_W-1:0]        out_tdata,  // red_out, green_out, blue_out
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [vca_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [vca_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import vca_pkg::*;

  localparam int W     = FRAC_BITS + 12;  // working value width
  localparam int KW    = FRAC_BITS + 3;   // coefficient and scale width
  localparam int SW    = FRAC_BITS + 2;   // unsigned scale width
  localparam int NSTG  = 5;

  // Fixed-point coefficients, rounded to nearest
  localparam logic signed [KW-1:0] K_RY = KW'(((longint'(CM_RY) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_GY = KW'(((longint'(CM_GY) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_BY = KW'(((longint'(CM_BY) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_RU = KW'(((longint'(CM_RU) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_GU = KW'(((longint'(CM_GU) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_BU = KW'(((longint'(CM_BU) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_RV = KW'(((longint'(CM_RV) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_GV = KW'(((longint'(CM_GV) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_BV = KW'(((longint'(CM_BV) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_VR = KW'(((longint'(CM_VR) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_UG = KW'(((longint'(CM_UG) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_VG = KW'(((longint'(CM_VG) <<< FRAC_BITS) + 500) / 1000);
  localparam logic signed [KW-1:0] K_UB = KW'(((longint'(CM_UB) <<< FRAC_BITS) + 500) / 1000);

  localparam logic signed [W-1:0] PIX_MAX = W'(longint'(255) <<< FRAC_BITS);

  // Fixed-point product, floored
  function automatic logic signed [W-1:0] fx_mul(logic signed [W-1:0] a,
                                                 logic signed [KW-1:0] k);
    logic signed [W+KW-1:0] p;
    p = a * k;
    return p[W+FRAC_BITS-1:FRAC_BITS];
  endfunction

  // Clamp to 0..255 and floor
  function automatic logic [PIX_W-1:0] pix_clamp(logic signed [W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > PIX_MAX) begin
      res = '1;
    end else begin
      res = v[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
    return res;
  endfunction

  // Integer tint chroma as fixed point
  function automatic logic signed [W-1:0] fx_int(int n);
    return W'(n) <<< FRAC_BITS;
  endfunction

  vca_adj_t      adj;
  logic [SW-1:0] sat_scale;
  logic [SW-1:0] con_scale;

  vca_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .adj       (adj),
    .sat_scale (sat_scale),
    .con_scale (con_scale)
  );

  logic signed [KW-1:0] sat_k;
  logic signed [KW-1:0] con_k;

  assign sat_k = $signed({1'b0, sat_scale});
  assign con_k = $signed({1'b0, con_scale});

  // Stage valid bits and per-stage load enables
  logic [NSTG:1] vld_r;
  logic [NSTG:1] rdy;

  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || out_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = vld_r[NSTG];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: RGB to YUV
  logic signed [W-1:0] r_w, g_w, b_w;
  logic signed [W-1:0] y1_nxt, u1_nxt, v1_nxt;
  logic signed [W-1:0] y1_r, u1_r, v1_r;

  assign r_w = {{(W-PIX_W){1'b0}}, in_tdata[PIX_W-1:0]};
  assign g_w = {{(W-PIX_W){1'b0}}, in_tdata[2*PIX_W-1:PIX_W]};
  assign b_w = {{(W-PIX_W){1'b0}}, in_tdata[3*PIX_W-1:2*PIX_W]};

  always_comb begin
    y1_nxt = W'(K_RY) * r_w + W'(K_GY) * g_w + W'(K_BY) * b_w;
    u1_nxt = W'(K_BU) * b_w - W'(K_RU) * r_w - W'(K_GU) * g_w;
    v1_nxt = W'(K_RV) * r_w - W'(K_GV) * g_w - W'(K_BV) * b_w;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      y1_r <= y1_nxt;
      u1_r <= u1_nxt;
      v1_r <= v1_nxt;
    end
  end

  // Stage 2: scale chroma by saturation
  logic signed [W-1:0] y2_r, u2_r, v2_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      y2_r <= y1_r;
      u2_r <= fx_mul(u1_r, sat_k);
      v2_r <= fx_mul(v1_r, sat_k);
    end
  end

  // Stage 3: scale luma and chroma by contrast
  logic signed [W-1:0] y3_r, u3_r, v3_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      y3_r <= fx_mul(y2_r, con_k);
      u3_r <= fx_mul(u2_r, con_k);
      v3_r <= fx_mul(v2_r, con_k);
    end
  end

  // Stage 4: brightness, tint select and back-conversion products
  logic signed [W-1:0] y4_nxt, u_t, v_t;
  logic signed [W-1:0] y4_r, pr4_r, pgu4_r, pgv4_r, pb4_r;

  always_comb begin
    y4_nxt = y3_r + (W'(adj.bright_ofs) <<< FRAC_BITS);
    case (adj.tint)
      TINT_BW: begin
        u_t = '0;
        v_t = '0;
      end
      TINT_PAPER: begin
        u_t = fx_int(PAPER_U);
        v_t = fx_int(PAPER_V);
      end
      TINT_GREEN: begin
        u_t = fx_int(GREEN_U);
        v_t = fx_int(GREEN_V);
      end
      TINT_AMBER: begin
        u_t = fx_int(AMBER_U);
        v_t = fx_int(AMBER_V);
      end
      TINT_SEPIA: begin
        u_t = fx_int(SEPIA_U);
        v_t = fx_int(SEPIA_V);
      end
      default: begin
        u_t = u3_r;
        v_t = v3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      y4_r   <= y4_nxt;
      pr4_r  <= fx_mul(v_t, K_VR);
      pgu4_r <= fx_mul(u_t, K_UG);
      pgv4_r <= fx_mul(v_t, K_VG);
      pb4_r  <= fx_mul(u_t, K_UB);
    end
  end

  // Stage 5: sum, clamp and hold the output word
  logic signed [W-1:0]  nr, ng, nb;
  logic [WORD_W-1:0]    out_nxt;
  logic [WORD_W-1:0]    out_r;

  always_comb begin
    nr      = y4_r + pr4_r;
    ng      = y4_r - pgu4_r - pgv4_r;
    nb      = y4_r + pb4_r;
    out_nxt = {pix_clamp(nb), pix_clamp(ng), pix_clamp(nr)};
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_r <= out_nxt;
    end
  end

  assign out_tdata = out_r;

endmodule

// File: tb/tb_video_color_adjust.sv
// Self-checking testbench for the video color adjust block: random and directed pixels.
module tb_video_color_adjust;
  timeunit 1ns;
  timeprecision 1ps;

  import vca_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) <<< FRAC;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata;   // red_in, green_in, blue_in
  logic                  out_tvalid;
  logic                  out_tready;
  logic [WORD_W-1:0]     out_tdata;  // red_out, green_out, blue_out
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Settings as the block currently holds them
  logic [6:0] bright_q = BRIGHTNESS_RST;
  logic [6:0] con_q    = CONTRAST_RST;
  logic [6:0] sat_q    = SATURATION_RST;
  logic [2:0] tint_q   = TINT_COLOR;

  pix_t expected_pix[$];
  int   bad_words = 0;
  bit   src_idle  = 1'b0;
  bit   sink_idle = 1'b0;
  int   hold_req  = 0;

  video_color_adjust #(.FRAC_BITS(FRAC)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Fixed-point coefficient from thousandths, rounded to nearest
  function automatic longint coef_fx(input int m);
    return ((longint'(m) <<< FRAC) + 500) / 1000;
  endfunction

  // Product of two fixed-point values, low bits dropped (floor)
  function automatic longint mul_fx(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic logic [7:0] chan_clamp(input longint v);
    if (v < 0) return 8'd0;
    if (v > 255 * ONE) return 8'd255;
    return v[FRAC+7:FRAC];
  endfunction

  // Adjusted pixel under the current settings
  function automatic pix_t predict_adjusted(input logic [7:0] r8, g8, b8);
    longint r, g, b, y, u, v, sat, con;
    pix_t   p;
    r = longint'(r8);
    g = longint'(g8);
    b = longint'(b8);
    sat = ((longint'(sat_q) <<< FRAC) + 25) / 50;
    con = ((longint'(con_q) <<< FRAC) + 50) / 100;
    y = coef_fx(299) * r + coef_fx(587) * g + coef_fx(114) * b;
    u = -coef_fx(147) * r - coef_fx(289) * g + coef_fx(436) * b;
    v = coef_fx(615) * r - coef_fx(515) * g - coef_fx(100) * b;
    u = mul_fx(u, sat);
    v = mul_fx(v, sat);
    y = mul_fx(y, con);
    u = mul_fx(u, con);
    v = mul_fx(v, con);
    y = y + (longint'(bright_q) - 50) * ONE;
    // Monochrome modes replace chroma; color mode and modes six and seven keep it
    case (tint_q)
      TINT_BW:    begin u = 0;          v = 0;         end
      TINT_PAPER: begin u = -8 * ONE;   v = 5 * ONE;   end
      TINT_GREEN: begin u = -99 * ONE;  v = -64 * ONE; end
      TINT_AMBER: begin u = -104 * ONE; v = 50 * ONE;  end
      TINT_SEPIA: begin u = -31 * ONE;  v = 26 * ONE;  end
      default: ;
    endcase
    p.red   = chan_clamp(y + mul_fx(coef_fx(1140), v));
    p.green = chan_clamp(y - mul_fx(coef_fx(396), u) - mul_fx(coef_fx(581), v));
    p.blue  = chan_clamp(y + mul_fx(coef_fx(2029), u));
    return p;
  endfunction

  // Offer one pixel, hold it until taken, then queue its expected word
  task automatic send_pixel(input logic [7:0] r, g, b);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    expected_pix.push_back(predict_adjusted(r, g, b));
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_pix.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Write all four registers; only called with the pipeline empty
  task automatic apply_settings(input logic [6:0] br, co, sa, input logic [2:0] tm);
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    write_reg(REG_BRIGHTNESS, br);
    write_reg(REG_CONTRAST, co);
    write_reg(REG_SATURATION, sa);
    write_reg(REG_TINT_MODE, {junk, tm});
    cfg_we <= 1'b0;
    @(posedge clk);
    bright_q = br;
    con_q    = co;
    sat_q    = sa;
    tint_q   = tm;
  endtask

  function automatic logic [6:0] pick_setting();
    case ($urandom_range(0, 5))
      0:       return 7'd0;
      1:       return 7'd100;
      2:       return 7'd127;
      3:       return 7'd50;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_directed_pixels();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'h55, 8'hAA, 8'h55);
    wait_drained();
  endtask

  // Every monochrome tint plus the two unused codes
  task automatic test_tint_modes();
    apply_settings(7'd50, 7'd100, 7'd50, TINT_BW);
    send_pixel(8'd200, 8'd120, 8'd40);
    wait_drained();
    apply_settings(7'd50, 7'd100, 7'd50, TINT_PAPER);
    send_pixel(8'd200, 8'd120, 8'd40);
    wait_drained();
    apply_settings(7'd50, 7'd100, 7'd50, TINT_GREEN);
    send_pixel(8'd200, 8'd120, 8'd40);
    wait_drained();
    apply_settings(7'd50, 7'd100, 7'd50, TINT_AMBER);
    send_pixel(8'd200, 8'd120, 8'd40);
    wait_drained();
    apply_settings(7'd50, 7'd100, 7'd50, TINT_SEPIA);
    send_pixel(8'd200, 8'd120, 8'd40);
    wait_drained();
    apply_settings(7'd50, 7'd100, 7'd50, 3'd6);
    send_pixel(8'd200, 8'd120, 8'd40);
    wait_drained();
    apply_settings(7'd50, 7'd100, 7'd50, 3'd7);
    send_pixel(8'd40, 8'd200, 8'd120);
    wait_drained();
  endtask

  // Settings at zero, at full scale and beyond full scale
  task automatic test_setting_extremes();
    apply_settings(7'd0, 7'd0, 7'd0, TINT_COLOR);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd10, 8'd250, 8'd90);
    wait_drained();
    apply_settings(7'd127, 7'd127, 7'd127, TINT_COLOR);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd30, 8'd0);
    wait_drained();
    apply_settings(7'd100, 7'd100, 7'd100, TINT_COLOR);
    send_pixel(8'd128, 8'd64, 8'd192);
    wait_drained();
  endtask

  // Long receiver hold-off fills the pipeline; then the sender pauses
  task automatic test_backpressure();
    apply_settings(7'd60, 7'd90, 7'd70, TINT_COLOR);
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 60;
    repeat (40) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
    wait_drained();
    repeat (10) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  // Random settings per phase, random pixels within each phase
  task automatic test_random_settings();
    logic [7:0] r, g, b;
    for (int ph = 0; ph < 30; ph++) begin
      apply_settings(pick_setting(), pick_setting(), pick_setting(),
                     3'($urandom_range(0, 7)));
      src_idle  = $urandom_range(0, 2) != 0;
      sink_idle = $urandom_range(0, 2) != 0;
      for (int i = 0; i < 40; i++) begin
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
          0: begin
            r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end
          1: begin
            g = r;
            b = r;
          end
          default: ;
        endcase
        send_pixel(r, g, b);
      end
      wait_drained();
    end
  endtask

  // Receiver: random stalls per word, plus any requested long hold-off
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = sink_idle ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    pix_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_pix.size() == 0) begin
        bad_words++;
        if (bad_words <= 10) $display("unexpected output word %h", out_tdata);
      end else begin
        want = expected_pix.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_pixels();
    test_tint_modes();
    test_setting_extremes();
    test_backpressure();
    test_random_settings();
    wait_drained();
    repeat (12) @(posedge clk);
    if (bad_words == 0 && expected_pix.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #500000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
